// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the geofence speed severity RTL.
// Defining NO_ASSERTIONS removes every assertion.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// plain property checked on every clock edge outside reset
`define GSS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gss assertion failed");

// same-cycle implication checked outside reset
`define GSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gss implication failed");

// next-cycle implication checked outside reset
`define GSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gss next-cycle implication failed");

`else

`define GSS_ASSERT(label, clk, rst_n, prop)
`define GSS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/gss_pkg.sv -----
// ----------------------------------------------------------------------------
// gss_pkg
// Sizes, function codes, controller/datapath interface types and the beep
// pattern table of the geofence speed severity unit.
// ----------------------------------------------------------------------------
package gss_pkg;

    // zone table geometry
    localparam int MAX_ZONES    = 4;
    localparam int MAX_VERTICES = 8;
    localparam int ZONE_W       = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int MEM_DEPTH    = MAX_ZONES * MAX_VERTICES;
    localparam int ADDR_W       = $clog2(MEM_DEPTH);

    // field widths
    localparam int FUNC_W   = 2;
    localparam int ZIDX_W   = 2;
    localparam int VIDX_W   = 3;
    localparam int LAT_W    = 31;
    localparam int LON_W    = 32;
    localparam int VCNT_W   = 4;
    localparam int SPEED_W  = 9;
    localparam int MARGIN_W = 6;
    localparam int SEV_W    = 2;
    localparam int IVL_W    = 14;
    localparam int DUR_W    = 9;
    localparam int TONE_W   = 12;

    // edge arithmetic widths
    localparam int DLAT_W = LAT_W + 1;
    localparam int DLON_W = LON_W + 1;
    localparam int PROD_W = DLAT_W + DLON_W + 1;

    localparam logic [MARGIN_W-1:0] WARN_MARGIN_RESET = MARGIN_W'(5);

    // transaction function codes
    localparam logic [FUNC_W-1:0] FUNC_WR_VTX = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_HDR = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

    // severity codes
    localparam logic [SEV_W-1:0] SEV_NONE    = 2'd0;
    localparam logic [SEV_W-1:0] SEV_CAUTION = 2'd1;
    localparam logic [SEV_W-1:0] SEV_NEAR    = 2'd2;
    localparam logic [SEV_W-1:0] SEV_OVER    = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic              wr_vtx;
        logic              wr_hdr;
        logic              start;
        logic              rd_en;
        logic              rd_prime;
        logic              rd_last;
        logic [ZONE_W-1:0] rd_zone;
        logic [VTX_W-1:0]  rd_vtx;
        logic              load_out;
    } gss_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic             zone_valid;
        logic [CNT_W-1:0] zone_count;
        logic             pipe_busy;
    } gss_sts_t;

    // tag carried alongside each vertex down the edge pipeline
    typedef struct packed {
        logic              prime;
        logic              last;
        logic [ZONE_W-1:0] zone;
    } gss_tag_t;

    typedef struct packed {
        logic [IVL_W-1:0]  interval_ms;
        logic [DUR_W-1:0]  duration_ms;
        logic [TONE_W-1:0] tone_hz;
    } gss_beep_t;

    // flat vertex memory address of a zone slot
    function automatic logic [ADDR_W-1:0] vtx_addr(input logic [ZONE_W-1:0] zone,
                                                   input logic [VTX_W-1:0] vtx);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(zone) * ADDR_W'(MAX_VERTICES);
        return base + ADDR_W'(vtx);
    endfunction

    // fixed beep pattern for each severity
    function automatic gss_beep_t beep_of(input logic [SEV_W-1:0] sev);
        gss_beep_t b;
        unique case (sev)
            SEV_CAUTION: b = '{IVL_W'(10000), DUR_W'(150), TONE_W'(1500)};
            SEV_NEAR:    b = '{IVL_W'(2000),  DUR_W'(200), TONE_W'(2000)};
            SEV_OVER:    b = '{IVL_W'(1000),  DUR_W'(300), TONE_W'(2500)};
            default:     b = '{IVL_W'(0),     DUR_W'(0),   TONE_W'(0)};
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/gss_datapath.sv -----
// ----------------------------------------------------------------------------
// gss_datapath
// Zone tables, vertex memory, four-stage edge crossing pipeline, severity
// accumulation and the result register.
// ----------------------------------------------------------------------------
module gss_datapath import gss_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  gss_cmd_t                  cmd,
    output gss_sts_t                  sts,
    input  logic                      cfg_wr_en,
    input  logic [MARGIN_W-1:0]       cfg_wr_data,
    input  logic [ZIDX_W-1:0]         s_zone_index,
    input  logic [VIDX_W-1:0]         s_vertex_index,
    input  logic signed [LAT_W-1:0]   s_latitude,
    input  logic signed [LON_W-1:0]   s_longitude,
    input  logic [VCNT_W-1:0]         s_vertex_count,
    input  logic [SPEED_W-1:0]        s_speed_limit,
    input  logic                      s_zone_enable,
    input  logic [SPEED_W-1:0]        s_speed,
    output logic                      m_in_zone,
    output logic [SEV_W-1:0]          m_severity,
    output logic [IVL_W-1:0]          m_interval_ms,
    output logic [DUR_W-1:0]          m_duration_ms,
    output logic [TONE_W-1:0]         m_tone_hz
);

    // configuration and zone header tables
    logic [MARGIN_W-1:0] margin_reg;
    logic [CNT_W-1:0]    zone_cnt_reg [MAX_ZONES];
    logic [SPEED_W-1:0]  zone_lim_reg [MAX_ZONES];
    logic                zone_vld_reg [MAX_ZONES];

    // vertex memory
    logic signed [LAT_W-1:0] lat_mem [MEM_DEPTH];
    logic signed [LON_W-1:0] lon_mem [MEM_DEPTH];

    // query operands
    logic signed [LAT_W-1:0] q_lat_reg;
    logic signed [LON_W-1:0] q_lon_reg;
    logic [SPEED_W-1:0]      q_speed_reg;

    // stage 0: memory read data
    logic                    v1_reg;
    gss_tag_t                t1_reg;
    logic signed [LAT_W-1:0] rd_lat_reg;
    logic signed [LON_W-1:0] rd_lon_reg;
    logic signed [LAT_W-1:0] prev_lat_reg;
    logic signed [LON_W-1:0] prev_lon_reg;

    // stage 1: differences
    logic                     v2_reg;
    gss_tag_t                 t2_reg;
    logic                     cross2_reg;
    logic signed [DLON_W-1:0] dy2_reg;
    logic signed [DLAT_W-1:0] a2_reg;
    logic signed [DLAT_W-1:0] b2_reg;
    logic signed [DLON_W-1:0] c2_reg;

    // stage 2: cross products
    logic                     v3_reg;
    gss_tag_t                 t3_reg;
    logic                     cross3_reg;
    logic                     dypos3_reg;
    logic signed [PROD_W-1:0] lhs3_reg;
    logic signed [PROD_W-1:0] rhs3_reg;

    // accumulation and result
    logic              parity_reg;
    logic              any_reg;
    logic [SEV_W-1:0]  sev_reg;
    logic              out_in_zone_reg;
    logic [SEV_W-1:0]  out_sev_reg;
    gss_beep_t         out_beep_reg;

    logic              zone_ok;
    logic              vtx_ok;
    logic [ZONE_W-1:0] wr_zone;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  cnt_sat;

    logic                     cross_next;
    logic signed [DLON_W-1:0] dy_next;
    logic signed [DLAT_W-1:0] a_next;
    logic signed [DLAT_W-1:0] b_next;
    logic signed [DLON_W-1:0] c_next;
    logic signed [PROD_W-1:0] lhs_next;
    logic signed [PROD_W-1:0] rhs_next;

    logic              hit;
    logic              parity_next;
    logic              in_poly;
    logic [SPEED_W-1:0] limit;
    logic [SPEED_W:0]  speed_plus_margin;
    logic [SEV_W-1:0]  zone_sev;
    logic              any_next;
    logic [SEV_W-1:0]  sev_next;

    // write decode
    always_comb begin
        zone_ok = (s_zone_index < MAX_ZONES);
        vtx_ok  = (s_vertex_index < MAX_VERTICES);
        wr_zone = ZONE_W'(s_zone_index);
        wr_addr = vtx_addr(wr_zone, VTX_W'(s_vertex_index));
        rd_addr = vtx_addr(cmd.rd_zone, cmd.rd_vtx);
        cnt_sat = (s_vertex_count > MAX_VERTICES) ? CNT_W'(MAX_VERTICES)
                                                  : CNT_W'(s_vertex_count);
    end

    // status for the scan sequencer
    always_comb begin
        sts.zone_valid = zone_vld_reg[cmd.rd_zone];
        sts.zone_count = zone_cnt_reg[cmd.rd_zone];
        sts.pipe_busy  = v1_reg | v2_reg | v3_reg;
    end

    // warn margin register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_reg <= WARN_MARGIN_RESET;
        end else if (cfg_wr_en) begin
            margin_reg <= cfg_wr_data;
        end
    end

    // zone headers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int z = 0; z < MAX_ZONES; z++) begin
                zone_cnt_reg[z] <= '0;
                zone_lim_reg[z] <= '0;
                zone_vld_reg[z] <= 1'b0;
            end
        end else if (cmd.wr_hdr && zone_ok) begin
            zone_cnt_reg[wr_zone] <= cnt_sat;
            zone_lim_reg[wr_zone] <= s_speed_limit;
            zone_vld_reg[wr_zone] <= s_zone_enable;
        end
    end

    // vertex memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (cmd.wr_vtx && zone_ok && vtx_ok) begin
            lat_mem[wr_addr] <= s_latitude;
            lon_mem[wr_addr] <= s_longitude;
        end
        if (cmd.rd_en) begin
            rd_lat_reg <= lat_mem[rd_addr];
            rd_lon_reg <= lon_mem[rd_addr];
        end
    end

    // query operand capture
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            q_lat_reg   <= s_latitude;
            q_lon_reg   <= s_longitude;
            q_speed_reg <= s_speed;
        end
    end

    // edge differences against the previous vertex
    always_comb begin
        cross_next = (rd_lon_reg > q_lon_reg) != (prev_lon_reg > q_lon_reg);
        dy_next    = DLON_W'(prev_lon_reg) - DLON_W'(rd_lon_reg);
        a_next     = DLAT_W'(q_lat_reg) - DLAT_W'(rd_lat_reg);
        b_next     = DLAT_W'(prev_lat_reg) - DLAT_W'(rd_lat_reg);
        c_next     = DLON_W'(q_lon_reg) - DLON_W'(rd_lon_reg);
    end

    // cross products
    always_comb begin
        lhs_next = PROD_W'(a2_reg) * PROD_W'(dy2_reg);
        rhs_next = PROD_W'(b2_reg) * PROD_W'(c2_reg);
    end

    // pipeline valid and tag flow
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge aclk) begin
        t1_reg <= '{cmd.rd_prime, cmd.rd_last, cmd.rd_zone};
        if (v1_reg) begin
            prev_lat_reg <= rd_lat_reg;
            prev_lon_reg <= rd_lon_reg;
        end
        t2_reg     <= t1_reg;
        cross2_reg <= cross_next;
        dy2_reg    <= dy_next;
        a2_reg     <= a_next;
        b2_reg     <= b_next;
        c2_reg     <= c_next;
        t3_reg     <= t2_reg;
        cross3_reg <= cross2_reg;
        dypos3_reg <= !dy2_reg[DLON_W-1] && (dy2_reg != '0);
        lhs3_reg   <= lhs_next;
        rhs3_reg   <= rhs_next;
    end

    // crossing parity and zone severity
    always_comb begin
        hit         = dypos3_reg ? (lhs3_reg < rhs3_reg) : (lhs3_reg > rhs3_reg);
        parity_next = t3_reg.prime ? 1'b0 : (parity_reg ^ (cross3_reg && hit));
        in_poly     = v3_reg && t3_reg.last && !t3_reg.prime && parity_next;
        limit       = zone_lim_reg[t3_reg.zone];
        speed_plus_margin = (SPEED_W + 1)'(q_speed_reg) + (SPEED_W + 1)'(margin_reg);
        if (q_speed_reg >= limit) begin
            zone_sev = SEV_OVER;
        end else if (speed_plus_margin >= (SPEED_W + 1)'(limit)) begin
            zone_sev = SEV_NEAR;
        end else begin
            zone_sev = SEV_CAUTION;
        end
        any_next = any_reg;
        sev_next = sev_reg;
        if (in_poly) begin
            any_next = 1'b1;
            if (zone_sev > sev_reg) begin
                sev_next = zone_sev;
            end
        end
    end

    // accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            parity_reg <= 1'b0;
            any_reg    <= 1'b0;
            sev_reg    <= SEV_NONE;
        end else if (cmd.start) begin
            parity_reg <= 1'b0;
            any_reg    <= 1'b0;
            sev_reg    <= SEV_NONE;
        end else if (v3_reg) begin
            parity_reg <= parity_next;
            any_reg    <= any_next;
            sev_reg    <= sev_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_in_zone_reg <= any_reg;
            out_sev_reg     <= sev_reg;
            out_beep_reg    <= beep_of(sev_reg);
        end
    end

    assign m_in_zone     = out_in_zone_reg;
    assign m_severity    = out_sev_reg;
    assign m_interval_ms = out_beep_reg.interval_ms;
    assign m_duration_ms = out_beep_reg.duration_ms;
    assign m_tone_hz     = out_beep_reg.tone_hz;

endmodule

// ----- rtl/gss_ctrl.sv -----
// ----------------------------------------------------------------------------
// gss_ctrl
// Transaction decode and zone/vertex scan sequencer; owns the output valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gss_ctrl import gss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [FUNC_W-1:0] s_func,
    output logic              m_valid,
    input  logic              m_ready,
    output gss_cmd_t          cmd,
    input  gss_sts_t          sts
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]        state_reg,  state_next;
    logic [ZONE_W-1:0] zone_reg,   zone_next;
    logic [CNT_W-1:0]  step_reg,   step_next;
    logic              m_valid_reg, m_valid_next;

    logic accept;
    logic zone_live;
    logic last_zone;
    logic advance;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        zone_next  = zone_reg;
        step_next  = step_reg;
        advance    = 1'b0;
        cmd        = '0;
        cmd.rd_zone = zone_reg;
        zone_live  = sts.zone_valid && (sts.zone_count != '0);
        last_zone  = (zone_reg == ZONE_W'(MAX_ZONES - 1));

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_func)
                        FUNC_WR_VTX: cmd.wr_vtx = 1'b1;
                        FUNC_WR_HDR: cmd.wr_hdr = 1'b1;
                        FUNC_QUERY: begin
                            cmd.start  = 1'b1;
                            zone_next  = '0;
                            step_next  = '0;
                            state_next = ST_SCAN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN: begin
                if (!zone_live) begin
                    advance = 1'b1;
                end else begin
                    // step 0 loads the closing vertex, then one edge per step
                    cmd.rd_en    = 1'b1;
                    cmd.rd_prime = (step_reg == '0);
                    cmd.rd_last  = (step_reg == sts.zone_count);
                    cmd.rd_vtx   = cmd.rd_prime ? VTX_W'(sts.zone_count - CNT_W'(1))
                                                : VTX_W'(step_reg - CNT_W'(1));
                    if (cmd.rd_last) begin
                        step_next = '0;
                        advance   = 1'b1;
                    end else begin
                        step_next = step_reg + CNT_W'(1);
                    end
                end
                if (advance) begin
                    if (last_zone) begin
                        state_next = ST_DRAIN;
                    end else begin
                        zone_next = zone_reg + ZONE_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (!sts.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // output valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            zone_reg    <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            zone_reg    <= zone_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result never overwrites one still waiting
    `GSS_ASSERT_IMPL(a_load_free, aclk, aresetn, cmd.load_out, !m_valid_reg || m_ready)
    // pipeline is empty whenever a new transaction can be taken
    `GSS_ASSERT_IMPL(a_idle_empty, aclk, aresetn, state_reg == ST_IDLE, !sts.pipe_busy)
    // the step counter never runs past the zone's vertex count
    `GSS_ASSERT_IMPL(a_step_range, aclk, aresetn, cmd.rd_en, step_reg <= sts.zone_count)
    // a zone scan ends by leaving the last zone into the drain
    `GSS_ASSERT_NEXT(a_scan_to_drain, aclk, aresetn,
                     state_reg == ST_SCAN && state_next != ST_SCAN, state_reg == ST_DRAIN)

endmodule

// ----- rtl/geofence_speed_severity_unit.sv -----
// ----------------------------------------------------------------------------
// geofence_speed_severity_unit
// Top level: even-odd ray casting over a loadable table of polygon zones with
// speed severity and beep pattern reporting.
// ----------------------------------------------------------------------------
// Vertex writes (func 0) and zone header writes (func 1) return nothing. A
// position query (func 2) walks every valid zone through a vertex memory
// with one write and one registered read port, one vertex per cycle; the
// closing vertex of each zone is read first and a skipped zone is passed
// over. Around the scan come the accept, the pipeline drain and the result
// load; a result still waiting on m_ready holds the load and the input
// until it is taken. The edge test runs in a four-stage pipeline (memory
// read, differences, two 32x33 cross products, compare), so zones overlap
// and only the final drain is exposed. One result transaction comes back
// per query, all zero outside every zone. Vertex slots never written read
// as garbage; warn_margin must be written through cfg_wr_en/cfg_wr_data only
// while the unit is idle, which the block itself does not enforce.
module geofence_speed_severity_unit import gss_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [MARGIN_W-1:0]       cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [FUNC_W-1:0]         s_func,
    input  logic [ZIDX_W-1:0]         s_zone_index,
    input  logic [VIDX_W-1:0]         s_vertex_index,
    input  logic signed [LAT_W-1:0]   s_latitude,
    input  logic signed [LON_W-1:0]   s_longitude,
    input  logic [VCNT_W-1:0]         s_vertex_count,
    input  logic [SPEED_W-1:0]        s_speed_limit,
    input  logic                      s_zone_enable,
    input  logic [SPEED_W-1:0]        s_speed,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_in_zone,
    output logic [SEV_W-1:0]          m_severity,
    output logic [IVL_W-1:0]          m_interval_ms,
    output logic [DUR_W-1:0]          m_duration_ms,
    output logic [TONE_W-1:0]         m_tone_hz
);

    gss_cmd_t cmd;
    gss_sts_t sts;

    // sequencer
    gss_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_func  (s_func),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // tables, edge pipeline and result register
    gss_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_zone_index   (s_zone_index),
        .s_vertex_index (s_vertex_index),
        .s_latitude     (s_latitude),
        .s_longitude    (s_longitude),
        .s_vertex_count (s_vertex_count),
        .s_speed_limit  (s_speed_limit),
        .s_zone_enable  (s_zone_enable),
        .s_speed        (s_speed),
        .m_in_zone      (m_in_zone),
        .m_severity     (m_severity),
        .m_interval_ms  (m_interval_ms),
        .m_duration_ms  (m_duration_ms),
        .m_tone_hz      (m_tone_hz)
    );

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the geofence speed severity unit. Loads polygon
// zones, fires position queries and compares every alert transaction with an
// in-bench ray casting predictor, under random source gaps and sink stalls
// and across several warn margin settings.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import gss_pkg::*;

    localparam int HALF_PERIOD = 10;
    localparam int DRAIN_CYCLES = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_MAX = 5;
    localparam int PHASE_ITEMS = 450;
    localparam int REPORT_CAP = 40;
    localparam int SPEED_MAX = 400;
    localparam int MARGIN_MAX = 50;
    localparam longint LAT_MAX = 900000000;
    localparam longint LON_MAX = 1800000000;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    typedef struct {
        logic [FUNC_W-1:0]       func;
        logic [ZIDX_W-1:0]       zone;
        logic [VIDX_W-1:0]       vtx;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
        logic [VCNT_W-1:0]       count;
        logic [SPEED_W-1:0]      limit;
        logic                    enable;
        logic [SPEED_W-1:0]      speed;
    } fence_cmd_t;

    typedef struct {
        logic              in_zone;
        logic [SEV_W-1:0]  severity;
        logic [IVL_W-1:0]  interval_ms;
        logic [DUR_W-1:0]  duration_ms;
        logic [TONE_W-1:0] tone_hz;
    } alert_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [MARGIN_W-1:0]     cfg_wr_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [FUNC_W-1:0]       s_func = '0;
    logic [ZIDX_W-1:0]       s_zone_index = '0;
    logic [VIDX_W-1:0]       s_vertex_index = '0;
    logic signed [LAT_W-1:0] s_latitude = '0;
    logic signed [LON_W-1:0] s_longitude = '0;
    logic [VCNT_W-1:0]       s_vertex_count = '0;
    logic [SPEED_W-1:0]      s_speed_limit = '0;
    logic                    s_zone_enable = 1'b0;
    logic [SPEED_W-1:0]      s_speed = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_in_zone;
    logic [SEV_W-1:0]        m_severity;
    logic [IVL_W-1:0]        m_interval_ms;
    logic [DUR_W-1:0]        m_duration_ms;
    logic [TONE_W-1:0]       m_tone_hz;

    // predictor copy of the zone table and margin
    logic signed [LAT_W-1:0] fence_lat [MEM_DEPTH] = '{default: '0};
    logic signed [LON_W-1:0] fence_lon [MEM_DEPTH] = '{default: '0};
    bit                      slot_loaded [MEM_DEPTH] = '{default: 1'b0};
    logic [VCNT_W-1:0]       fence_count [MAX_ZONES] = '{default: '0};
    logic [SPEED_W-1:0]      fence_limit [MAX_ZONES] = '{default: '0};
    bit                      fence_on [MAX_ZONES] = '{default: 1'b0};
    logic [MARGIN_W-1:0]     margin_kmh = WARN_MARGIN_RESET;

    // stimulus geometry of each zone
    longint zone_clat [MAX_ZONES] = '{default: 0};
    longint zone_clon [MAX_ZONES] = '{default: 0};
    longint zone_span [MAX_ZONES] = '{default: 0};

    alert_t      pending_alerts [$];
    int unsigned error_count = 0;
    int unsigned items_sent = 0;
    int unsigned tx_gap_max = 0;
    int unsigned rx_stall_max = 0;
    int unsigned rx_hold_cycles = 0;

    geofence_speed_severity_unit i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_zone_index   (s_zone_index),
        .s_vertex_index (s_vertex_index),
        .s_latitude     (s_latitude),
        .s_longitude    (s_longitude),
        .s_vertex_count (s_vertex_count),
        .s_speed_limit  (s_speed_limit),
        .s_zone_enable  (s_zone_enable),
        .s_speed        (s_speed),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_in_zone      (m_in_zone),
        .m_severity     (m_severity),
        .m_interval_ms  (m_interval_ms),
        .m_duration_ms  (m_duration_ms),
        .m_tone_hz      (m_tone_hz)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // even-odd crossing count with exact cross products
    function automatic bit zone_contains(int z, longint plat, longint plon);
        int n, j, base;
        bit hit;
        longint xi, yi, xj, yj;
        logic signed [65:0] dy, d_pt, d_edge, d_lon, cross_pt, cross_edge;
        hit = 1'b0;
        n = fence_count[z];
        base = z * MAX_VERTICES;
        if (n == 0) begin
            return 1'b0;
        end
        j = n - 1;
        for (int i = 0; i < n; i++) begin
            xi = fence_lat[base + i];
            yi = fence_lon[base + i];
            xj = fence_lat[base + j];
            yj = fence_lon[base + j];
            if ((yi > plon) != (yj > plon)) begin
                dy = yj - yi;
                d_pt = plat - xi;
                d_edge = xj - xi;
                d_lon = plon - yi;
                cross_pt = d_pt * dy;
                cross_edge = d_edge * d_lon;
                // comparison flips for edges running down in longitude
                if ((dy > 0) ? (cross_pt < cross_edge) : (cross_pt > cross_edge)) begin
                    hit = !hit;
                end
            end
            j = i;
        end
        return hit;
    endfunction

    // worst severity over every live zone holding the point
    function automatic alert_t predict_alert(longint plat, longint plon, int spd);
        alert_t a;
        logic [SEV_W-1:0] worst, here;
        int lim;
        a = '{default: '0};
        worst = SEV_NONE;
        for (int z = 0; z < MAX_ZONES; z++) begin
            if (fence_on[z] && zone_contains(z, plat, plon)) begin
                a.in_zone = 1'b1;
                lim = fence_limit[z];
                if (spd >= lim) begin
                    here = SEV_OVER;
                end else if (spd >= lim - int'(margin_kmh)) begin
                    here = SEV_NEAR;
                end else begin
                    here = SEV_CAUTION;
                end
                if (here > worst) begin
                    worst = here;
                end
            end
        end
        a.severity = worst;
        case (worst)
            SEV_CAUTION: begin
                a.interval_ms = 10000;
                a.duration_ms = 150;
                a.tone_hz = 1500;
            end
            SEV_NEAR: begin
                a.interval_ms = 2000;
                a.duration_ms = 200;
                a.tone_hz = 2000;
            end
            SEV_OVER: begin
                a.interval_ms = 1000;
                a.duration_ms = 300;
                a.tone_hz = 2500;
            end
            default: ;
        endcase
        return a;
    endfunction

    // update the table copy, or queue the alert a query must return
    function automatic void apply_command(fence_cmd_t c);
        int slot;
        slot = int'(c.zone) * MAX_VERTICES + int'(c.vtx);
        case (c.func)
            FUNC_WR_VTX: begin
                fence_lat[slot] = c.lat;
                fence_lon[slot] = c.lon;
                slot_loaded[slot] = 1'b1;
            end
            FUNC_WR_HDR: begin
                fence_count[c.zone] = (c.count > MAX_VERTICES) ? VCNT_W'(MAX_VERTICES) : c.count;
                fence_limit[c.zone] = c.limit;
                fence_on[c.zone] = c.enable;
            end
            FUNC_QUERY: begin
                pending_alerts.push_back(predict_alert(c.lat, c.lon, c.speed));
            end
            default: ;
        endcase
    endfunction

    function automatic longint clamp_to(longint v, longint lim);
        if (v > lim) begin
            return lim;
        end
        if (v < -lim) begin
            return -lim;
        end
        return v;
    endfunction

    function automatic longint rand_around(longint ctr, longint span, longint lim);
        return clamp_to(ctr + longint'($urandom_range(0, 32'(2 * span))) - span, lim);
    endfunction

    function automatic int random_limit();
        if ($urandom_range(0, 9) == 0) begin
            return $urandom_range(0, 1) ? SPEED_MAX : 0;
        end
        return $urandom_range(0, SPEED_MAX);
    endfunction

    // every field random within its range
    function automatic fence_cmd_t random_cmd();
        fence_cmd_t c;
        c.func = FUNC_W'($urandom_range(0, FUNC_NONE));
        c.zone = ZIDX_W'($urandom);
        c.vtx = VIDX_W'($urandom);
        c.lat = LAT_W'(rand_around(0, LAT_MAX, LAT_MAX));
        c.lon = LON_W'(rand_around(0, LON_MAX, LON_MAX));
        c.count = VCNT_W'($urandom);
        c.limit = SPEED_W'($urandom_range(0, SPEED_MAX));
        c.enable = 1'($urandom);
        c.speed = SPEED_W'($urandom_range(0, SPEED_MAX));
        return c;
    endfunction

    function automatic fence_cmd_t vertex_cmd(int z, int v, longint la, longint lo);
        fence_cmd_t c;
        c = random_cmd();
        c.func = FUNC_WR_VTX;
        c.zone = ZIDX_W'(z);
        c.vtx = VIDX_W'(v);
        c.lat = LAT_W'(la);
        c.lon = LON_W'(lo);
        return c;
    endfunction

    function automatic fence_cmd_t header_cmd(int z, int cnt, int lim, bit en);
        fence_cmd_t c;
        int need;
        c = random_cmd();
        c.func = FUNC_WR_HDR;
        c.zone = ZIDX_W'(z);
        c.count = VCNT_W'(cnt);
        c.limit = SPEED_W'(lim);
        need = (cnt > MAX_VERTICES) ? MAX_VERTICES : cnt;
        // a live zone must never walk a vertex slot that was never loaded
        for (int v = 0; v < need; v++) begin
            if (!slot_loaded[z * MAX_VERTICES + v]) begin
                en = 1'b0;
            end
        end
        c.enable = en;
        return c;
    endfunction

    function automatic fence_cmd_t query_cmd(longint la, longint lo, int spd);
        fence_cmd_t c;
        c = random_cmd();
        c.func = FUNC_QUERY;
        c.lat = LAT_W'(la);
        c.lon = LON_W'(lo);
        c.speed = SPEED_W'(spd);
        return c;
    endfunction

    // query around a zone, often right on a vertex or near its limit
    function automatic fence_cmd_t query_near(int z);
        fence_cmd_t c;
        longint reach;
        int spd, mar;
        int slot;
        c = random_cmd();
        c.func = FUNC_QUERY;
        if ($urandom_range(0, 9) == 0) begin
            slot = z * MAX_VERTICES + int'($urandom_range(0, MAX_VERTICES - 1));
            c.lat = fence_lat[slot];
            c.lon = fence_lon[slot];
        end else begin
            reach = zone_span[z] + zone_span[z] / 4 + 1;
            c.lat = LAT_W'(rand_around(zone_clat[z], reach, LAT_MAX));
            c.lon = LON_W'(rand_around(zone_clon[z], reach, LON_MAX));
        end
        if ($urandom_range(0, 1) == 1) begin
            mar = int'(margin_kmh);
            spd = int'(fence_limit[z]) - mar - 2 + int'($urandom_range(0, mar + 4));
            if (spd < 0) begin
                spd = 0;
            end
            if (spd > SPEED_MAX) begin
                spd = SPEED_MAX;
            end
            c.speed = SPEED_W'(spd);
        end
        return c;
    endfunction

    // offer one transaction and wait for the handshake
    task automatic send_cmd(fence_cmd_t c);
        int unsigned gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= c.func;
        s_zone_index <= c.zone;
        s_vertex_index <= c.vtx;
        s_latitude <= c.lat;
        s_longitude <= c.lon;
        s_vertex_count <= c.count;
        s_speed_limit <= c.limit;
        s_zone_enable <= c.enable;
        s_speed <= c.speed;
        do @(posedge aclk); while (!s_ready);
        apply_command(c);
        if (c.func != FUNC_NONE) begin
            items_sent++;
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_alerts.size() != 0) @(posedge aclk);
    endtask

    // margin only changes once the unit has gone quiet
    task automatic set_margin(logic [MARGIN_W-1:0] m);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= m;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        margin_kmh = m;
    endtask

    // random polygon around a random center, then its header
    task automatic build_zone(int z);
        int n;
        int unsigned pick;
        longint span;
        pick = $urandom_range(0, 99);
        span = (pick < 30) ? 20 : (pick < 60) ? 3000 : (pick < 90) ? 400000 : LAT_MAX;
        zone_span[z] = span;
        zone_clat[z] = rand_around(0, LAT_MAX, LAT_MAX);
        zone_clon[z] = rand_around(0, LON_MAX, LON_MAX);
        n = $urandom_range(3, MAX_VERTICES);
        for (int v = 0; v < MAX_VERTICES; v++) begin
            send_cmd(vertex_cmd(z, v, rand_around(zone_clat[z], span, LAT_MAX),
                                rand_around(zone_clon[z], span, LON_MAX)));
        end
        pick = $urandom_range(0, 99);
        if (pick >= 85) begin
            n = $urandom_range(0, 2);
        end else if (pick >= 70) begin
            n = $urandom_range(MAX_VERTICES + 1, (1 << VCNT_W) - 1);
        end
        send_cmd(header_cmd(z, n, random_limit(), $urandom_range(0, 9) != 0));
    endtask

    // mostly zone builds and queries near zones, some noise
    task automatic run_random_traffic(int unsigned count);
        int unsigned goal, next_mode, pick;
        fence_cmd_t c;
        goal = items_sent + count;
        next_mode = items_sent;
        while (items_sent < goal) begin
            if (items_sent >= next_mode) begin
                tx_gap_max = $urandom_range(0, 1) ? IDLE_MAX : 0;
                rx_stall_max = $urandom_range(0, 1) ? IDLE_MAX : 0;
                next_mode = items_sent + $urandom_range(40, 160);
            end
            pick = $urandom_range(0, 99);
            if (pick < 7) begin
                build_zone($urandom_range(0, MAX_ZONES - 1));
            end else if (pick < 12) begin
                c = random_cmd();
                c.func = FUNC_WR_VTX;
                send_cmd(c);
            end else if (pick < 15) begin
                send_cmd(header_cmd($urandom_range(0, MAX_ZONES - 1),
                                    $urandom_range(0, (1 << VCNT_W) - 1),
                                    random_limit(), $urandom_range(0, 1)));
            end else if (pick < 17) begin
                c = random_cmd();
                c.func = FUNC_NONE;
                send_cmd(c);
            end else if (pick < 23) begin
                c = random_cmd();
                c.func = FUNC_QUERY;
                send_cmd(c);
            end else begin
                send_cmd(query_near($urandom_range(0, MAX_ZONES - 1)));
            end
        end
    endtask

    task automatic test_directed_cases();
        fence_cmd_t c;
        tx_gap_max = IDLE_MAX;
        rx_stall_max = IDLE_MAX;
        // empty table
        send_cmd(query_cmd(0, 0, 50));
        // triangle over the extreme coordinates
        send_cmd(vertex_cmd(0, 0, -LAT_MAX, -LON_MAX));
        send_cmd(vertex_cmd(0, 1, LAT_MAX, -LON_MAX));
        send_cmd(vertex_cmd(0, 2, 0, LON_MAX));
        send_cmd(header_cmd(0, 3, 100, 1'b1));
        send_cmd(query_cmd(0, 0, 0));
        send_cmd(query_cmd(0, 0, 95));
        send_cmd(query_cmd(0, 0, 100));
        send_cmd(query_cmd(-LAT_MAX, -LON_MAX, SPEED_MAX));
        send_cmd(query_cmd(LAT_MAX, LON_MAX, SPEED_MAX));
        // unused function code
        c = random_cmd();
        c.func = FUNC_NONE;
        send_cmd(c);
        // two vertices never enclose anything
        send_cmd(vertex_cmd(1, 0, -10, -10));
        send_cmd(vertex_cmd(1, 1, 10, 10));
        send_cmd(header_cmd(1, 2, 10, 1'b1));
        send_cmd(query_cmd(0, 0, 97));
        // margin wider than the limit
        send_cmd(header_cmd(0, 3, 3, 1'b1));
        send_cmd(query_cmd(0, 0, 1));
        // zero limit
        send_cmd(header_cmd(0, 3, 0, 1'b1));
        send_cmd(query_cmd(0, 0, 0));
        // disabled zone
        send_cmd(header_cmd(0, 3, 100, 1'b0));
        send_cmd(query_cmd(0, 0, 0));
    endtask

    task automatic test_warn_margins();
        logic [MARGIN_W-1:0] sweep [4];
        sweep = '{MARGIN_W'(0), MARGIN_W'(MARGIN_MAX), MARGIN_W'($urandom_range(1, MARGIN_MAX - 1)),
                  WARN_MARGIN_RESET};
        for (int p = 0; p < 4; p++) begin
            set_margin(sweep[p]);
            if (p == 0) begin
                for (int z = 0; z < MAX_ZONES; z++) build_zone(z);
            end
            run_random_traffic(PHASE_ITEMS);
        end
    endtask

    // sink holds off while the source keeps queries coming
    task automatic test_output_backpressure();
        wait_drained();
        tx_gap_max = 0;
        rx_stall_max = 0;
        rx_hold_cycles = HOLD_CYCLES;
        for (int q = 0; q < 40; q++) send_cmd(query_near($urandom_range(0, MAX_ZONES - 1)));
        wait_drained();
    endtask

    // source goes quiet until every alert is back
    task automatic test_drain_pause();
        for (int r = 0; r < 3; r++) begin
            run_random_traffic(15);
            wait_drained();
        end
    endtask

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            error_count++;
            if (error_count <= REPORT_CAP) begin
                $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        end
    endfunction

    // compare each alert transaction with the oldest prediction
    always @(posedge aclk) begin : alert_check
        alert_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_alerts.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_CAP) begin
                    $display("%0t ns: unexpected alert, expected none, got severity %0d",
                             $time, m_severity);
                end
            end else begin
                want = pending_alerts.pop_front();
                check_field("in_zone", want.in_zone, m_in_zone);
                check_field("severity", want.severity, m_severity);
                check_field("interval_ms", want.interval_ms, m_interval_ms);
                check_field("duration_ms", want.duration_ms, m_duration_ms);
                check_field("tone_hz", want.tone_hz, m_tone_hz);
            end
        end
    end

    // alert sink with random stalls and one long hold-off
    initial begin : alert_sink
        int unsigned stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_cycles > 0) begin
                stall = rx_hold_cycles;
                rx_hold_cycles = 0;
            end else begin
                stall = $urandom_range(0, rx_stall_max);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                for (int n = 0; n < stall; n++) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // give up after a long stretch without any transaction
    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t ns: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_cases();
        test_warn_margins();
        test_output_backpressure();
        test_drain_pause();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
